FILE: rtl/upd_pkg.sv
package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // Most decoded bytes one input byte can cause
  localparam int unsigned MAX_OUT = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Bytes caused by one input beat, first byte in slot 0
  typedef struct packed {
    logic [1:0]               cnt;
    logic [MAX_OUT-1:0][7:0]  data;
    logic                     last;
  } grp_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] t;
    h = '0;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      h.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + HEX_TEN;
      h.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + HEX_TEN;
      h.ok = 1'b1;
    end
    h.val = t[3:0];
    return h;
  endfunction

endpackage

FILE: rtl/upd_front.sv
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  upd_pkg::in_item_t in_data,
  input  upd_pkg::q_stat_t  q_stat,
  output logic            grp_push,
  output upd_pkg::grp_t   grp
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;

  assign accept = push && !q_stat.full;

  always_comb begin
    hex_t       hb;
    hex_t       hh;
    logic [1:0] n;
    logic       do_fresh;
    logic [7:0] b;
    b         = in_data.in_byte;
    hb        = hex_decode(b);
    hh        = hex_decode(held_r);
    n         = '0;
    do_fresh  = 1'b0;
    grp       = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;

    unique case (phase_r)
      PH_PCT: begin
        if (hb.ok) begin
          held_nxt  = b;
          phase_nxt = PH_DIG;
        end else begin
          phase_nxt   = PH_IDLE;
          grp.data[n] = CH_PCT;
          n           = n + 2'd1;
          do_fresh    = 1'b1;
        end
      end
      PH_DIG: begin
        phase_nxt = PH_IDLE;
        if (hb.ok) begin
          grp.data[n] = {hh.val, hb.val};
          n           = n + 2'd1;
        end else begin
          grp.data[n] = CH_PCT;
          n           = n + 2'd1;
          grp.data[n] = held_r;
          n           = n + 2'd1;
          do_fresh    = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        do_fresh  = 1'b1;
      end
    endcase

    if (do_fresh) begin
      if (b == CH_PLUS) begin
        grp.data[n] = CH_SPACE;
        n           = n + 2'd1;
      end else if (b == CH_PCT) begin
        phase_nxt = PH_PCT;
      end else begin
        grp.data[n] = b;
        n           = n + 2'd1;
      end
    end

    // flush whatever is still held at end of string
    if (in_data.in_last) begin
      if (phase_nxt == PH_PCT) begin
        grp.data[n] = CH_PCT;
        n           = n + 2'd1;
      end else if (phase_nxt == PH_DIG) begin
        grp.data[n] = CH_PCT;
        n           = n + 2'd1;
        grp.data[n] = held_nxt;
        n           = n + 2'd1;
      end
      phase_nxt = PH_IDLE;
      grp.last  = 1'b1;
    end

    grp.cnt = n;
  end

  assign grp_push = accept && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: rtl/upd_gq.sv
module upd_gq #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  upd_pkg::grp_t   wr_data,
  input  logic            rd,
  output upd_pkg::grp_t   rd_data,
  output upd_pkg::q_stat_t stat
);
  import upd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wrap_inc(wp_r);
      end
      if (do_rd) begin
        rp_r <= wrap_inc(rp_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/upd_back.sv
module upd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  upd_pkg::grp_t    head,
  input  upd_pkg::q_stat_t q_stat,
  output logic             head_pop,
  output logic             out_empty,
  input  logic             pop,
  output upd_pkg::out_item_t out_data
);
  import upd_pkg::*;

  logic       ov_r;
  out_item_t  od_r;
  logic [1:0] idx_r;
  logic       load, at_end;

  assign at_end    = (idx_r == head.cnt - 2'd1);
  assign load      = !q_stat.empty && (!ov_r || pop);
  assign head_pop  = load && at_end;
  assign out_empty = !ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (load) begin
      od_r.out_byte <= head.data[idx_r];
      od_r.out_last <= head.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/url_percent_decoder_top.sv
// Channel   Direction  Handshake              Payload
// input     in         push / in_full         in_data   (in_byte, in_last)
// result    out        out_empty / pop        out_data  (out_byte, out_last)
//
// One input beat per cycle while the group queue is not full; a beat that
// yields k bytes (up to three) becomes k result beats, and the back-end
// serialiser sets the sustained rate of one result beat per cycle while pop is
// held. An input beat is registered in the group queue, then in the output
// register. Reset is synchronous, active low: clear the phase, the group queue
// and the output valid flag. in_full rises only when the group queue is
// full; stalls on pop back up through it, not blocking the front end till then.
module url_percent_decoder_top #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               in_full,
  input  upd_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               pop,
  output upd_pkg::out_item_t out_data
);
  import upd_pkg::*;

  grp_t    grp_w, head_w;
  logic    grp_push, head_pop;
  q_stat_t q_stat;

  // Front end: classify each byte, advance the pending state, build one group
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .grp_push (grp_push),
    .grp      (grp_w)
  );

  // Group queue: decouple the front end from output back-pressure
  upd_gq #(
    .DEPTH (QDEPTH)
  ) u_gq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (grp_push),
    .wr_data (grp_w),
    .rd      (head_pop),
    .rd_data (head_w),
    .stat    (q_stat)
  );

  // Back end: serialise each group into result beats, one per cycle while pop is held
  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_w),
    .q_stat    (q_stat),
    .head_pop  (head_pop),
    .out_empty (out_empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  assign in_full = q_stat.full;

endmodule

FILE: tb/sv/url_percent_decoder_top_test.sv
module url_percent_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  // Random part length, and how long the receiver blocks to force back-pressure
  localparam int RANDOM_BEATS  = 440;
  localparam int HOLD_CYCLES   = 80;
  // Up to three bytes per beat; wait after the drain so stray result beats can show
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_SHOWN     = 10;
  localparam int NOT_HEX       = -1;
  // A row whose output bytes come from the predictor rather than the row itself
  localparam int USE_PREDICTOR = -1;

  // One row of directed stimulus; n_typed >= 0 means the decoded bytes are
  // written into the row by hand
  typedef struct {
    in_item_t        beat;
    int              n_typed;
    logic [2:0][7:0] typed;
  } stim_row_t;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      push     = 1'b0;
  logic      pop      = 1'b0;
  in_item_t  in_data  = '0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_data;

  // Receiver hold-off, armed from the stimulus and timed in its own process
  logic      holding  = 1'b0;
  event      hold_ev;

  // Idle rates in percent, changed between the phases of the random part
  int tx_idle_pct = 9;
  int rx_idle_pct = 71;

  // Decoder shadow state
  phase_t     pred_phase = PH_IDLE;
  logic [7:0] pred_held  = '0;
  out_item_t  pred_buf [MAX_OUT];
  int         pred_n;

  out_item_t  decoded_q [$];   // decoded bytes still owed by the block
  stim_row_t  typed_q [$];     // one entry per offered beat, in offer order
  stim_row_t  stim_rows [$];
  stim_row_t  row_now;
  out_item_t  want;

  int err_cnt      = 0;
  int checked_cnt  = 0;
  int accepted_cnt = 0;
  int escape_cnt   = 0;
  int stall_cnt    = 0;

  url_percent_decoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Value of a hex digit character, either case; NOT_HEX for anything else
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + int'(HEX_TEN);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + int'(HEX_TEN);
    return NOT_HEX;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    pred_buf[pred_n].out_byte = b;
    pred_buf[pred_n].out_last = 1'b0;
    pred_n++;
  endfunction

  // Handle a byte with nothing pending: plus to space, percent opens an escape
  function automatic void take_fresh(input logic [7:0] b);
    if (b == CH_PLUS) emit_byte(CH_SPACE);
    else if (b == CH_PCT) pred_phase = PH_PCT;
    else emit_byte(b);
  endfunction

  // Work out the decoded bytes one input beat causes, into pred_buf/pred_n
  function automatic void decode_beat(input in_item_t beat);
    int v;
    int hi;
    v = nibble_of(beat.in_byte);
    pred_n = 0;
    case (pred_phase)
      PH_PCT: begin
        if (v != NOT_HEX) begin
          pred_held  = beat.in_byte;
          pred_phase = PH_DIG;
        end else begin
          // escape broken straight after the percent: release it literally
          pred_phase = PH_IDLE;
          emit_byte(CH_PCT);
          take_fresh(beat.in_byte);
        end
      end
      PH_DIG: begin
        if (v != NOT_HEX) begin
          hi = nibble_of(pred_held);
          pred_phase = PH_IDLE;
          emit_byte({hi[3:0], v[3:0]});
          escape_cnt++;
        end else begin
          // escape broken after the first digit: release percent and digit
          pred_phase = PH_IDLE;
          emit_byte(CH_PCT);
          emit_byte(pred_held);
          take_fresh(beat.in_byte);
        end
      end
      default: begin
        pred_phase = PH_IDLE;
        take_fresh(beat.in_byte);
      end
    endcase
    if (beat.in_last) begin
      // end of string: flush whatever is still pending
      if (pred_phase == PH_PCT) begin
        emit_byte(CH_PCT);
      end else if (pred_phase == PH_DIG) begin
        emit_byte(CH_PCT);
        emit_byte(pred_held);
      end
      pred_phase = PH_IDLE;
      if (pred_n > 0) pred_buf[pred_n - 1].out_last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: log accepted input beats, check accepted result beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && push) begin
      if (in_full) begin
        stall_cnt++;
      end else begin
        row_now = typed_q.pop_front();
        decode_beat(in_data);
        // a hand-written row overrides the predicted bytes, keep its state
        if (row_now.n_typed != USE_PREDICTOR) begin
          pred_n = row_now.n_typed;
          for (int i = 0; i < pred_n; i++) begin
            pred_buf[i].out_byte = row_now.typed[i];
            pred_buf[i].out_last = in_data.in_last && (i == pred_n - 1);
          end
        end
        for (int i = 0; i < pred_n; i++) decoded_q.push_back(pred_buf[i]);
        accepted_cnt++;
      end
    end
    if (rst_n && pop && !out_empty) begin
      if (decoded_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected result beat: byte %h last %b",
                   out_data.out_byte, out_data.out_last);
      end else begin
        want = decoded_q.pop_front();
        checked_cnt++;
        if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("result beat %0d: expected byte %h last %b, got byte %h last %b",
                     checked_cnt, want.out_byte, want.out_last,
                     out_data.out_byte, out_data.out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pop at random, drop pop completely while a hold-off runs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= !holding && ($urandom_range(99) >= rx_idle_pct);
  end

  always begin
    @(hold_ev);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  function automatic stim_row_t mk_row(input logic [7:0] b, input logic l, input int n,
                                       input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2);
    stim_row_t r;
    r.beat.in_byte = b;
    r.beat.in_last = l;
    r.n_typed      = n;
    r.typed        = {b2, b1, b0};
    return r;
  endfunction

  // Random hex digit character, random case for letters
  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(v - 10);
  endfunction

  // Offer one beat, idling first at the current rate; return at the edge
  // that accepts it so the next beat can follow back to back
  task automatic send_beat(input stim_row_t row);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back(row);
    push    <= 1'b1;
    in_data <= row.beat;
    do @(posedge clk); while (in_full);
  endtask

  initial begin
    stim_row_t free_row;
    in_item_t  gen_q [$];
    int        k;
    int        len;
    int        random_sent;

    free_row.beat    = '0;
    free_row.n_typed = USE_PREDICTOR;
    free_row.typed   = '0;
    random_sent      = 0;

    // Directed rows. Bytes: 34 '4', 31 '1', 66 'f', 46 'F', 61 'a', 67 'g',
    // 7A 'z', 42 'B', 39 '9', 47 'G'.
    // plain extremes, the second closing a string
    stim_rows.push_back(mk_row(8'h00,   1'b0, 1, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'hFF,   1'b1, 1, 8'hFF, 8'h00, 8'h00));
    // plus to space
    stim_rows.push_back(mk_row(CH_PLUS, 1'b0, 1, CH_SPACE, 8'h00, 8'h00));
    // %41 -> 'A'
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h34,   1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h31,   1'b0, 1, 8'h41, 8'h00, 8'h00));
    // %fF -> FF, mixed case, ends the string
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h66,   1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h46,   1'b1, 1, 8'hFF, 8'h00, 8'h00));
    // %00 -> 00
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(CH_0,    1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(CH_0,    1'b0, 1, 8'h00, 8'h00, 8'h00));
    // broken after percent, the breaking plus still turns into a space
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(CH_PLUS, 1'b0, 2, CH_PCT, CH_SPACE, 8'h00));
    // broken after the first digit: three bytes out of one beat
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h61,   1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h67,   1'b0, 3, CH_PCT, 8'h61, 8'h67));
    // a second percent restarts the escape, then breaks it at end of string
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 1, CH_PCT, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h7A,   1'b1, 2, CH_PCT, 8'h7A, 8'h00));
    // end of string flushes a lone percent, then a percent and digit
    stim_rows.push_back(mk_row(CH_PCT,  1'b1, 1, CH_PCT, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, 0, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h42,   1'b1, 2, CH_PCT, 8'h42, 8'h00));
    // percent breaking a digit escape opens a new one
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, USE_PREDICTOR, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h39,   1'b0, USE_PREDICTOR, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(CH_PCT,  1'b0, USE_PREDICTOR, 8'h00, 8'h00, 8'h00));
    stim_rows.push_back(mk_row(8'h47,   1'b1, USE_PREDICTOR, 8'h00, 8'h00, 8'h00));

    // hold reset, then release it for good
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_beat(stim_rows[i]);

    // Random strings in three phases: slow receiver, slow sender, then flat out
    // with one long receiver hold-off to fill the block and stall its input.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          -> hold_ev;
        end
      endcase
      while (random_sent < (ph + 1) * RANDOM_BEATS / 3) begin
        gen_q.delete();
        len = $urandom_range(1, 6);
        if ($urandom_range(99) < 8) begin
          // noise: raw bytes with no structure
          repeat (len) gen_q.push_back(in_item_t'({8'($urandom_range(255)), 1'b0}));
        end else begin
          repeat (len) begin
            k = $urandom_range(99);
            if (k < 35) begin
              gen_q.push_back(in_item_t'({8'($urandom_range(255)), 1'b0}));
            end else if (k < 45) begin
              gen_q.push_back(in_item_t'({CH_PLUS, 1'b0}));
            end else if (k < 80) begin
              // well-formed escape
              gen_q.push_back(in_item_t'({CH_PCT, 1'b0}));
              gen_q.push_back(in_item_t'({rand_hex_char(), 1'b0}));
              gen_q.push_back(in_item_t'({rand_hex_char(), 1'b0}));
            end else if (k < 90) begin
              gen_q.push_back(in_item_t'({CH_PCT, 1'b0}));
              gen_q.push_back(in_item_t'({8'($urandom_range(255)), 1'b0}));
            end else begin
              gen_q.push_back(in_item_t'({CH_PCT, 1'b0}));
              gen_q.push_back(in_item_t'({rand_hex_char(), 1'b0}));
              gen_q.push_back(in_item_t'({8'($urandom_range(255)), 1'b0}));
            end
          end
          // leave an escape open at the end now and then so it gets flushed
          k = $urandom_range(99);
          if (k < 10) begin
            gen_q.push_back(in_item_t'({CH_PCT, 1'b0}));
          end else if (k < 20) begin
            gen_q.push_back(in_item_t'({CH_PCT, 1'b0}));
            gen_q.push_back(in_item_t'({rand_hex_char(), 1'b0}));
          end
        end
        gen_q[gen_q.size() - 1].in_last = 1'b1;
        foreach (gen_q[i]) begin
          free_row.beat = gen_q[i];
          send_beat(free_row);
          random_sent++;
        end
      end
    end
    push <= 1'b0;

    // drain, then give the block time to show any stray beats
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input beats and %0d decoded result beats, %0d of them full escapes",
             accepted_cnt, checked_cnt, escape_cnt);
    $display("input held off by a full block for %0d cycles in total", stall_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("timed out with %0d result beats outstanding", decoded_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
